// File: hdl/ising_checkerboard_metropolis_assert.svh
// Assertion macros for the checkerboard Ising update block.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef ISING_CHECKERBOARD_METROPOLIS_ASSERT_SVH
`define ISING_CHECKERBOARD_METROPOLIS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ising checkerboard check failed");

// Consequent must hold in the cycle after the antecedent.
`define ICM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ising checkerboard check failed");

`endif

// File: hdl/icm_pkg.sv
// Shared constants, codes and a helper function for the checkerboard Ising update block.
// No dependencies.
package icm_pkg;

  // Lattice geometry (the lattice side is even, so row parity alternates around the wrap).
  localparam int SIDE       = 64;
  localparam int HALF_ROW   = SIDE / 2;
  localparam int ROW_W      = (SIDE > 2) ? $clog2(SIDE) : 1;
  localparam int COL_W      = ROW_W;
  localparam int K_W        = (HALF_ROW > 1) ? $clog2(HALF_ROW) : 1;
  localparam int BANK_DEPTH = SIDE / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Field widths.
  localparam int THR_W  = 17;
  localparam int RND_W  = 16;
  localparam int SITE_W = 12;
  localparam int SUM_W  = 14;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register reset values.
  localparam logic [THR_W-1:0] THR_EIGHT_RESET = THR_W'(1928);
  localparam logic [THR_W-1:0] THR_FOUR_RESET  = THR_W'(11240);

  // Spin sum of the checkerboard start.
  localparam logic signed [SUM_W-1:0] CHECKER_SUM = SUM_W'(SIDE % 2);

  // Register index codes (taken from address bit 2).
  localparam logic REG_THR_EIGHT = 1'b0;
  localparam logic REG_THR_FOUR  = 1'b1;

  // Command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  // Neighbour agreement counts that need the random acceptance test.
  localparam logic [2:0] AGREE_ALL   = 3'd4;
  localparam logic [2:0] AGREE_THREE = 3'd3;

  // One lattice row of the checkerboard start: up where row plus column is even.
  function automatic logic [SIDE-1:0] checker_row(input logic odd_row);
    logic [SIDE-1:0] v;
    for (int c = 0; c < SIDE; c++) begin
      v[c] = ((c & 1) == 1) == odd_row;
    end
    return v;
  endfunction

endpackage

// File: hdl/ising_checkerboard_metropolis.sv
// An accepted item moves into the stage-two registers, then into the output register.
// One item per cycle unless the result channel stalls; stage one reads three lattice rows from two
// row-parity banks, stage two decides the move and writes the row back while loading the result.
// Reset (rst_n, synchronous) and the reinitialise command restore the checkerboard at once
// through per-row valid flags; there is no clearing pass. Thresholds return to defaults on reset.
// Depends on icm_pkg and ising_checkerboard_metropolis_assert.svh.
`include "ising_checkerboard_metropolis_assert.svh"

module ising_checkerboard_metropolis (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [icm_pkg::RND_W-1:0]      in_random_fraction,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [icm_pkg::SITE_W-1:0]     out_site_index,
  output logic                           out_flipped,
  output logic                           out_new_spin,
  output logic signed [icm_pkg::SUM_W-1:0] out_spin_sum,
  output logic                           out_sweep_end,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [icm_pkg::ADDR_W-1:0]     paddr,
  input  logic [icm_pkg::DATA_W-1:0]     pwdata,
  output logic [icm_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import icm_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SIDE - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SIDE - 1);
  localparam logic [K_W-1:0]   LAST_K   = K_W'(HALF_ROW - 1);

  // Configuration registers
  logic [THR_W-1:0] thr_eight_r;
  logic [THR_W-1:0] thr_four_r;
  logic             cfg_wr;

  // Sweep position: pass, row and half-row step
  logic             pass_r;
  logic [ROW_W-1:0] row_r;
  logic [K_W-1:0]   k_r;
  logic             pass_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [K_W-1:0]   k_nxt;

  // Stage one decode
  logic             acc;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] up0;
  logic [ROW_W-1:0] dn0;
  logic             end0;
  logic [BANK_AW-1:0] mid_a, up_a, dn_a;
  logic [BANK_AW-1:0] b0_a0, b0_a1, b1_a0, b1_a1;

  // Row banks, split by row parity
  logic [SIDE-1:0] bank0_mem [BANK_DEPTH];
  logic [SIDE-1:0] bank1_mem [BANK_DEPTH];
  logic [SIDE-1:0] b0q0_r, b0q1_r, b1q0_r, b1q1_r;

  // Stage two registers
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [RND_W-1:0] s1_rnd_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [ROW_W-1:0] s1_up_r;
  logic [ROW_W-1:0] s1_dn_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_end_r;
  logic             s1_adv;

  // Row state: valid flags and the last row written
  logic [SIDE-1:0]  row_valid_r;
  logic             lw_valid_r;
  logic [ROW_W-1:0] lw_row_r;
  logic [SIDE-1:0]  lw_word_r;

  // Stage two logic
  logic [SIDE-1:0]  mem_mid, mem_up, mem_dn;
  logic [SIDE-1:0]  mid_w, up_w, dn_w;
  logic [COL_W-1:0] lcol, rcol;
  logic             spin_s;
  logic [2:0]       n_up;
  logic [2:0]       agree;
  logic [THR_W-1:0] rnd_ext;
  logic             flip_now;
  logic [SIDE-1:0]  new_word;
  logic             wr_en;
  logic [BANK_AW-1:0] wr_a;
  logic [SITE_W-1:0]  site_now;

  // Result register and running sum
  logic                    out_valid_r;
  logic [SITE_W-1:0]       out_site_r;
  logic                    out_flipped_r;
  logic                    out_spin_r;
  logic                    out_end_r;
  logic signed [SUM_W-1:0] spin_sum_r;
  logic signed [SUM_W-1:0] spin_sum_nxt;

  // Configuration port: writes in the access phase, reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_THR_FOUR) ? DATA_W'(thr_four_r) : DATA_W'(thr_eight_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_eight_r <= THR_EIGHT_RESET;
      thr_four_r  <= THR_FOUR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_THR_EIGHT) begin
        thr_eight_r <= pwdata[THR_W-1:0];
      end else begin
        thr_four_r <= pwdata[THR_W-1:0];
      end
    end
  end

  // Handshakes: stage two moves on when the result register is free or being taken.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign acc      = in_valid && in_ready;

  // Decode the current sweep position into site and neighbour rows.
  assign col0  = COL_W'({k_r, row_r[0] ^ pass_r});
  assign up0   = (row_r == '0) ? LAST_ROW : row_r - 1'b1;
  assign dn0   = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;
  assign end0  = pass_r && (row_r == LAST_ROW) && (k_r == LAST_K);
  assign mid_a = BANK_AW'(row_r >> 1);
  assign up_a  = BANK_AW'(up0 >> 1);
  assign dn_a  = BANK_AW'(dn0 >> 1);

  // The site row lies in one bank, both neighbour rows in the other.
  assign b0_a0 = row_r[0] ? up_a : mid_a;
  assign b0_a1 = dn_a;
  assign b1_a0 = row_r[0] ? mid_a : up_a;
  assign b1_a1 = dn_a;

  // Next sweep position, wrapping at the end of the sweep.
  always_comb begin
    pass_nxt = pass_r;
    row_nxt  = row_r;
    k_nxt    = k_r;
    if (k_r == LAST_K) begin
      k_nxt = '0;
      if (row_r == LAST_ROW) begin
        row_nxt  = '0;
        pass_nxt = !pass_r;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end else begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      row_r  <= '0;
      k_r    <= '0;
    end else if (acc) begin
      if (in_command == CMD_REINIT) begin
        pass_r <= 1'b0;
        row_r  <= '0;
        k_r    <= '0;
      end else begin
        pass_r <= pass_nxt;
        row_r  <= row_nxt;
        k_r    <= k_nxt;
      end
    end
  end

  // Stage two valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Stage two payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r <= in_command;
      s1_rnd_r <= in_random_fraction;
      s1_row_r <= row_r;
      s1_up_r  <= up0;
      s1_dn_r  <= dn0;
      s1_col_r <= col0;
      s1_end_r <= end0;
    end
  end

  // Even-row bank: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en && !s1_row_r[0]) begin
      bank0_mem[wr_a] <= new_word;
    end
    if (acc) begin
      b0q0_r <= bank0_mem[b0_a0];
      b0q1_r <= bank0_mem[b0_a1];
    end
  end

  // Odd-row bank: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en && s1_row_r[0]) begin
      bank1_mem[wr_a] <= new_word;
    end
    if (acc) begin
      b1q0_r <= bank1_mem[b1_a0];
      b1q1_r <= bank1_mem[b1_a1];
    end
  end

  // Pick the rows out of the banks by the parity of the site row.
  assign mem_mid = s1_row_r[0] ? b1q0_r : b0q0_r;
  assign mem_up  = s1_row_r[0] ? b0q0_r : b1q0_r;
  assign mem_dn  = s1_row_r[0] ? b0q1_r : b1q1_r;

  // Resolve each row: the write of the same edge as the read wins, then the bank if the
  // row has been written since the last restore, else the checkerboard pattern.
  always_comb begin
    if (lw_valid_r && (lw_row_r == s1_row_r)) begin
      mid_w = lw_word_r;
    end else if (row_valid_r[s1_row_r]) begin
      mid_w = mem_mid;
    end else begin
      mid_w = checker_row(s1_row_r[0]);
    end
    if (lw_valid_r && (lw_row_r == s1_up_r)) begin
      up_w = lw_word_r;
    end else if (row_valid_r[s1_up_r]) begin
      up_w = mem_up;
    end else begin
      up_w = checker_row(s1_up_r[0]);
    end
    if (lw_valid_r && (lw_row_r == s1_dn_r)) begin
      dn_w = lw_word_r;
    end else if (row_valid_r[s1_dn_r]) begin
      dn_w = mem_dn;
    end else begin
      dn_w = checker_row(s1_dn_r[0]);
    end
  end

  // Metropolis decision. Energy change is 4*agree - 8, where agree counts neighbours
  // equal to the site: four agreeing costs 8, three cost 4, fewer never cost.
  assign lcol    = (s1_col_r == '0) ? LAST_COL : s1_col_r - 1'b1;
  assign rcol    = (s1_col_r == LAST_COL) ? '0 : s1_col_r + 1'b1;
  assign spin_s  = mid_w[s1_col_r];
  assign n_up    = 3'(up_w[s1_col_r]) + 3'(dn_w[s1_col_r]) + 3'(mid_w[lcol]) + 3'(mid_w[rcol]);
  assign agree   = spin_s ? n_up : 3'd4 - n_up;
  assign rnd_ext = THR_W'(s1_rnd_r);

  always_comb begin
    if (s1_cmd_r == CMD_REINIT) begin
      flip_now = 1'b0;
    end else if (agree == AGREE_ALL) begin
      flip_now = rnd_ext <= thr_eight_r;
    end else if (agree == AGREE_THREE) begin
      flip_now = rnd_ext <= thr_four_r;
    end else begin
      flip_now = 1'b1;
    end
  end

  // Write the whole site row back when the spin flips.
  assign new_word = mid_w ^ (SIDE'(1) << s1_col_r);
  assign wr_en    = s1_adv && (s1_cmd_r == CMD_UPDATE) && flip_now;
  assign wr_a     = BANK_AW'(s1_row_r >> 1);
  assign site_now = SITE_W'(32'(s1_row_r) * SIDE + 32'(s1_col_r));

  // Row valid flags and the last-write record; a restore drops them all at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      lw_valid_r  <= 1'b0;
    end else if (s1_adv && (s1_cmd_r == CMD_REINIT)) begin
      row_valid_r <= '0;
      lw_valid_r  <= 1'b0;
    end else if (wr_en) begin
      row_valid_r[s1_row_r] <= 1'b1;
      lw_valid_r            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_row_r  <= s1_row_r;
      lw_word_r <= new_word;
    end
  end

  // Running spin sum.
  always_comb begin
    spin_sum_nxt = spin_sum_r;
    if (s1_cmd_r == CMD_REINIT) begin
      spin_sum_nxt = CHECKER_SUM;
    end else if (flip_now) begin
      spin_sum_nxt = spin_s ? spin_sum_r - SUM_W'(2) : spin_sum_r + SUM_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_sum_r <= CHECKER_SUM;
    end else if (s1_adv) begin
      spin_sum_r <= spin_sum_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_cmd_r == CMD_REINIT) begin
        out_site_r    <= '0;
        out_flipped_r <= 1'b0;
        out_spin_r    <= 1'b1;
        out_end_r     <= 1'b0;
      end else begin
        out_site_r    <= site_now;
        out_flipped_r <= flip_now;
        out_spin_r    <= spin_s ^ flip_now;
        out_end_r     <= s1_end_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_site_index = out_site_r;
  assign out_flipped    = out_flipped_r;
  assign out_new_spin   = out_spin_r;
  assign out_spin_sum   = spin_sum_r;
  assign out_sweep_end  = out_end_r;

  // A restore brings back the start sum and drops every written row.
  `ICM_ASSERT_NEXT(a_reinit_restores, s1_adv && (s1_cmd_r == CMD_REINIT), (spin_sum_r == CHECKER_SUM) && (row_valid_r == '0))

  // The last site of a sweep sends the position back to the start.
  `ICM_ASSERT_NEXT(a_sweep_wraps, acc && (in_command == CMD_UPDATE) && end0, !pass_r && (row_r == '0) && (k_r == '0))

  // An update moves the spin sum by at most one spin flip.
  `ICM_ASSERT_NEXT(a_sum_step, s1_adv && (s1_cmd_r == CMD_UPDATE), (spin_sum_r == $past(spin_sum_r)) || (spin_sum_r == $past(spin_sum_r) + SUM_W'(2)) || (spin_sum_r == $past(spin_sum_r) - SUM_W'(2)))

  // The forwarded row is always one the banks already hold.
  `ICM_ASSERT_SAME(a_forward_row_valid, lw_valid_r, row_valid_r[lw_row_r])

endmodule
